### hdl/assert_macros.svh
// Assertion macros used by the RTL of the queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define TSQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Condition that must be followed by a consequence in the next cycle.
`define TSQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TSQ_ASSERT(lbl, clk, rstn, prop, msg)
`define TSQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

### hdl/tsq_pkg.sv
// Package with the request operation codes and port widths of the two-stack queue.
`timescale 1ns / 1ps
`default_nettype none
package tsq_pkg;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PEEK = 2'd2
  } op_e;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned INDEX_W = 5;
  localparam int unsigned COUNT_W = 6;

endpackage
`default_nettype wire

### hdl/tsq_ram.sv
// Generic single-port RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none
module tsq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### hdl/two_stack_queue.sv
// Two-stack queue: one request is taken at start, its result strobes on done_o in the next cycle.
// busy is high during that result cycle, so a new request is taken only while no result is shown;
// the element RAM is single-port and has a registered read.
// Both stacks share one circular RAM of 2*STACK_DEPTH entries; a stack transfer only moves
// the depth counters, never data. Reset clears the counters and the head pointer at once;
// the RAM is not cleared and a request may be taken in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module two_stack_queue
  import tsq_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned DATA_WIDTH  = 32
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [OP_W-1:0]           op_i,
  input  wire logic signed [VALUE_W-1:0] value_i,
  input  wire logic [INDEX_W-1:0]        index_i,
  output logic                           done_o,
  output logic signed [VALUE_W-1:0]      data_o,
  output logic                           error_o,
  output logic [COUNT_W-1:0]             count_o,
  output logic                           is_full_o
);

  localparam int unsigned MEM_DEPTH = 2 * STACK_DEPTH;
  localparam int unsigned AW        = $clog2(MEM_DEPTH);
  localparam int unsigned DPW       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned CW        = DPW + 1;
  localparam int unsigned XW        = (CW > INDEX_W) ? CW : INDEX_W;
  localparam logic [DPW-1:0] SD_FULL = DPW'(STACK_DEPTH);
  localparam logic [AW:0]    MEM_LIM = (AW + 1)'(MEM_DEPTH);

  // Circular add of two addresses; both operands are below the memory depth.
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= MEM_LIM) begin
      sum = sum - MEM_LIM;
    end
    return sum[AW-1:0];
  endfunction

  logic           accept;
  logic [DPW-1:0] in_q, in_d;
  logic [DPW-1:0] out_q, out_d;
  logic [AW-1:0]  head_q, head_d;
  logic           pend_q;
  logic           err_q, err_d;
  logic           rsel_q, rsel_d;
  logic [COUNT_W-1:0] cnt_q;
  logic           full_q;
  logic [CW-1:0]  cnt_cur, cnt_nxt;
  logic           full_cur;
  logic           we;
  logic [AW-1:0]  addr;
  logic [DATA_WIDTH-1:0] wdata, rdata;
  logic [63:0]    val_ext, rd_ext;

  assign accept   = start && !pend_q;
  assign cnt_cur  = {1'b0, in_q} + {1'b0, out_q};
  assign full_cur = (in_q == SD_FULL) && (out_q != '0);
  assign val_ext  = {32'b0, value_i};
  assign wdata    = val_ext[DATA_WIDTH-1:0];

  always_comb begin
    in_d   = in_q;
    out_d  = out_q;
    head_d = head_q;
    err_d  = 1'b0;
    rsel_d = 1'b0;
    we     = 1'b0;
    addr   = head_q;
    case (op_e'(op_i))
      OP_ENQ: begin
        if (full_cur) begin
          err_d = 1'b1;
        end else begin
          // The tail sits count entries past the head; a full input stack over an
          // empty output stack becomes the output stack without moving data.
          addr = wrap_add(head_q, AW'(cnt_cur));
          we   = accept;
          if (in_q == SD_FULL) begin
            out_d = SD_FULL;
            in_d  = DPW'(1);
          end else begin
            in_d = in_q + DPW'(1);
          end
        end
      end
      OP_DEQ: begin
        if (cnt_cur == '0) begin
          err_d = 1'b1;
        end else begin
          rsel_d = 1'b1;
          head_d = wrap_add(head_q, AW'(1));
          if (out_q == '0) begin
            out_d = in_q - DPW'(1);
            in_d  = '0;
          end else begin
            out_d = out_q - DPW'(1);
          end
        end
      end
      OP_PEEK: begin
        if (XW'(index_i) < XW'(cnt_cur)) begin
          rsel_d = 1'b1;
          addr   = wrap_add(head_q, AW'(index_i));
        end else begin
          err_d = 1'b1;
        end
      end
      default: begin
        err_d = 1'b1;
      end
    endcase
  end

  assign cnt_nxt = {1'b0, in_d} + {1'b0, out_d};

  tsq_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(MEM_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q   <= '0;
      out_q  <= '0;
      head_q <= '0;
      pend_q <= 1'b0;
    end else begin
      pend_q <= accept;
      if (accept) begin
        in_q   <= in_d;
        out_q  <= out_d;
        head_q <= head_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      err_q  <= err_d;
      rsel_q <= rsel_d;
      cnt_q  <= COUNT_W'(cnt_nxt);
      full_q <= (in_d == SD_FULL) && (out_d != '0);
    end
  end

  assign rd_ext    = 64'(rdata);
  assign busy      = pend_q;
  assign done_o    = pend_q;
  assign data_o    = rsel_q ? rd_ext[VALUE_W-1:0] : '0;
  assign error_o   = err_q;
  assign count_o   = cnt_q;
  assign is_full_o = full_q;

  `TSQ_ASSERT(a_depth_range, clk_i, rst_ni, (in_q <= SD_FULL) && (out_q <= SD_FULL), "stack depth beyond STACK_DEPTH")
  `TSQ_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, start && !busy, done_o && !$past(done_o), "request without a result in the next cycle")
  `TSQ_ASSERT(a_error_zero, clk_i, rst_ni, !(done_o && error_o) || (data_o == '0), "error result carries nonzero data")
  `TSQ_ASSERT_NEXT(a_hold_idle, clk_i, rst_ni, !(start && !busy), $stable(in_q) && $stable(out_q) && $stable(head_q), "queue state changed without a request")

endmodule
`default_nettype wire
